[src/fss2d_pkg.sv]
// Shared types, constants and fixed-point helpers for the 2x2 finite-strain stress core.
// Used by every module under src; depends on nothing else.
`default_nettype none

package fss2d_pkg;

    localparam int QW     = 32;           // datapath width of one Q16.16 value
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * QW;       // full product of two values
    localparam int RND_W  = PROD_W - FRAC_W;
    localparam int SAT_W  = RND_W + 2;    // headroom for sums before clamping
    localparam int REG_W  = 31;           // configuration register width
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LAME_LAMBDA   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SHEAR_MODULUS = CFG_IDX_W'(1);

    localparam logic [REG_W-1:0] LAMBDA_RESET = REG_W'(81920);
    localparam logic [REG_W-1:0] MU_RESET     = REG_W'(65536);

    localparam logic signed [SAT_W-1:0]  ONE_S   = SAT_W'(65536);
    localparam logic signed [SAT_W-1:0]  LSB_S   = SAT_W'(1);
    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(32768);

    typedef logic signed [QW-1:0]     q_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [RND_W-1:0]  rnd_t;
    typedef logic signed [SAT_W-1:0]  wide_t;
    typedef logic [REG_W-1:0]         modulus_t;

    typedef struct packed {
        q_t grad_00;
        q_t grad_01;
        q_t grad_10;
        q_t grad_11;
    } grad_t;

    typedef struct packed {
        q_t stress_00;
        q_t stress_01;
        q_t stress_10;
        q_t stress_11;
    } stress_t;

    // general 2x2 tensor, used for the deformation gradient
    typedef struct packed {
        q_t t00;
        q_t t01;
        q_t t10;
        q_t t11;
    } tensor_t;

    // symmetric 2x2 tensor, used for strain and second Piola stress
    typedef struct packed {
        q_t t00;
        q_t t01;
        q_t t11;
    } sym_t;

    // clamp a wide signed value to the Q16.16 range
    function automatic q_t sat_q(input wide_t v);
        logic hi_same;
        hi_same = (v[SAT_W-1:QW-1] == {(SAT_W-QW+1){v[SAT_W-1]}});
        if (hi_same) begin
            return v[QW-1:0];
        end else if (v[SAT_W-1]) begin
            return {1'b1, {(QW-1){1'b0}}};
        end else begin
            return {1'b0, {(QW-1){1'b1}}};
        end
    endfunction

    // Q32.32 product to Q16.16, round half up
    function automatic rnd_t rnd_q(input prod_t p);
        prod_t r;
        r = p + HALF_LSB;
        return r[PROD_W-1:FRAC_W];
    endfunction

    function automatic wide_t widen_r(input rnd_t r);
        return SAT_W'(r);
    endfunction

    function automatic wide_t widen_q(input q_t q);
        return SAT_W'(q);
    endfunction

endpackage

`default_nettype wire

[src/fss2d_strain.sv]
// Deformation gradient and Green strain stages (three register stages).
// Depends on fss2d_pkg.
`default_nettype none

module fss2d_strain import fss2d_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire grad_t   in_grad,
    output logic         out_valid,
    output tensor_t      out_f,
    output sym_t         out_e
);

    // stage 1: F = G + I
    logic    v1_reg;
    tensor_t f1_reg, f1_next;
    // stage 2: products for F^T F
    logic    v2_reg;
    tensor_t f2_reg;
    prod_t   p00a_reg, p00b_reg, p01a_reg, p01b_reg, p11a_reg, p11b_reg;
    prod_t   p00a_next, p00b_next, p01a_next, p01b_next, p11a_next, p11b_next;
    // stage 3: E
    logic    v3_reg;
    tensor_t f3_reg;
    sym_t    e3_reg, e3_next;
    wide_t   c00, c01, c11;

    always_comb begin
        f1_next.t00 = sat_q(widen_q(in_grad.grad_00) + ONE_S);
        f1_next.t01 = in_grad.grad_01;
        f1_next.t10 = in_grad.grad_10;
        f1_next.t11 = sat_q(widen_q(in_grad.grad_11) + ONE_S);
    end

    always_comb begin
        p00a_next = f1_reg.t00 * f1_reg.t00;
        p00b_next = f1_reg.t10 * f1_reg.t10;
        p01a_next = f1_reg.t00 * f1_reg.t01;
        p01b_next = f1_reg.t10 * f1_reg.t11;
        p11a_next = f1_reg.t01 * f1_reg.t01;
        p11b_next = f1_reg.t11 * f1_reg.t11;
    end

    always_comb begin
        c00 = widen_r(rnd_q(p00a_reg)) + widen_r(rnd_q(p00b_reg)) - ONE_S + LSB_S;
        c01 = widen_r(rnd_q(p01a_reg)) + widen_r(rnd_q(p01b_reg)) + LSB_S;
        c11 = widen_r(rnd_q(p11a_reg)) + widen_r(rnd_q(p11b_reg)) - ONE_S + LSB_S;
        e3_next.t00 = sat_q(c00 >>> 1);
        e3_next.t01 = sat_q(c01 >>> 1);
        e3_next.t11 = sat_q(c11 >>> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg   <= f1_next;
            f2_reg   <= f1_reg;
            p00a_reg <= p00a_next;
            p00b_reg <= p00b_next;
            p01a_reg <= p01a_next;
            p01b_reg <= p01b_next;
            p11a_reg <= p11a_next;
            p11b_reg <= p11b_next;
            f3_reg   <= f2_reg;
            e3_reg   <= e3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_f     = f3_reg;
    assign out_e     = e3_reg;

endmodule

`default_nettype wire

[src/fss2d_stress.sv]
// Second Piola stress stages: trace, modulus products, S (three register stages).
// Depends on fss2d_pkg; carries F alongside for the final stage.
`default_nettype none

module fss2d_stress import fss2d_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     en,
    input  wire modulus_t lame_lambda,
    input  wire modulus_t shear_modulus,
    input  wire logic     in_valid,
    input  wire tensor_t  in_f,
    input  wire sym_t     in_e,
    output logic          out_valid,
    output tensor_t       out_f,
    output sym_t          out_s
);

    // stage 1: trace
    logic    v1_reg;
    tensor_t f1_reg;
    sym_t    e1_reg;
    q_t      tr1_reg, tr1_next;
    // stage 2: lambda and mu products
    logic    v2_reg;
    tensor_t f2_reg;
    prod_t   pt_reg, pm00_reg, pm01_reg, pm11_reg;
    prod_t   pt_next, pm00_next, pm01_next, pm11_next;
    q_t      lam_s, mu_s;
    // stage 3: S
    logic    v3_reg;
    tensor_t f3_reg;
    sym_t    s3_reg, s3_next;
    wide_t   t_w;

    assign tr1_next = sat_q(widen_q(in_e.t00) + widen_q(in_e.t11));

    always_comb begin
        lam_s     = signed'({1'b0, lame_lambda});
        mu_s      = signed'({1'b0, shear_modulus});
        pt_next   = lam_s * tr1_reg;
        pm00_next = mu_s * e1_reg.t00;
        pm01_next = mu_s * e1_reg.t01;
        pm11_next = mu_s * e1_reg.t11;
    end

    always_comb begin
        t_w = widen_r(rnd_q(pt_reg));
        s3_next.t00 = sat_q(t_w + (widen_r(rnd_q(pm00_reg)) <<< 1));
        s3_next.t01 = sat_q(widen_r(rnd_q(pm01_reg)) <<< 1);
        s3_next.t11 = sat_q(t_w + (widen_r(rnd_q(pm11_reg)) <<< 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg   <= in_f;
            e1_reg   <= in_e;
            tr1_reg  <= tr1_next;
            f2_reg   <= f1_reg;
            pt_reg   <= pt_next;
            pm00_reg <= pm00_next;
            pm01_reg <= pm01_next;
            pm11_reg <= pm11_next;
            f3_reg   <= f2_reg;
            s3_reg   <= s3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_f     = f3_reg;
    assign out_s     = s3_reg;

endmodule

`default_nettype wire

[src/fss2d_piola.sv]
// First Piola stress P = F S: product stage and the output register.
// Depends on fss2d_pkg.
`default_nettype none

module fss2d_piola import fss2d_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire tensor_t in_f,
    input  wire sym_t    in_s,
    output logic         out_valid,
    output stress_t      out_p
);

    // stage 1: eight products F_ik S_kj
    logic    v1_reg;
    prod_t   a00_reg, b00_reg, a01_reg, b01_reg, a10_reg, b10_reg, a11_reg, b11_reg;
    prod_t   a00_next, b00_next, a01_next, b01_next;
    prod_t   a10_next, b10_next, a11_next, b11_next;
    // stage 2: output register
    logic    v2_reg;
    stress_t p2_reg, p2_next;

    always_comb begin
        a00_next = in_f.t00 * in_s.t00;
        b00_next = in_f.t01 * in_s.t01;
        a01_next = in_f.t00 * in_s.t01;
        b01_next = in_f.t01 * in_s.t11;
        a10_next = in_f.t10 * in_s.t00;
        b10_next = in_f.t11 * in_s.t01;
        a11_next = in_f.t10 * in_s.t01;
        b11_next = in_f.t11 * in_s.t11;
    end

    always_comb begin
        p2_next.stress_00 = sat_q(widen_r(rnd_q(a00_reg)) + widen_r(rnd_q(b00_reg)));
        p2_next.stress_01 = sat_q(widen_r(rnd_q(a01_reg)) + widen_r(rnd_q(b01_reg)));
        p2_next.stress_10 = sat_q(widen_r(rnd_q(a10_reg)) + widen_r(rnd_q(b10_reg)));
        p2_next.stress_11 = sat_q(widen_r(rnd_q(a11_reg)) + widen_r(rnd_q(b11_reg)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a00_reg <= a00_next;
            b00_reg <= b00_next;
            a01_reg <= a01_next;
            b01_reg <= b01_next;
            a10_reg <= a10_next;
            b10_reg <= b10_next;
            a11_reg <= a11_next;
            b11_reg <= b11_next;
            p2_reg  <= p2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_p     = p2_reg;

endmodule

`default_nettype wire

[src/finite_strain_stress_2d_core.sv]
// Top level: Saint Venant-Kirchhoff first Piola stress for 2x2 gradients, Q16.16.
// Holds the Lame registers and pipeline flow control; depends on fss2d_pkg,
// fss2d_strain, fss2d_stress and fss2d_piola.
//
//   channel   direction  handshake               payload
//   s_        in         s_valid / s_ready       s_data   (grad_t)
//   m_        out        m_valid / m_ready       m_data   (stress_t)
//   cfg_      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Eight register stages: F, F^T F products, E, trace, modulus products, S,
// F S products, output register. One gradient per cycle while the output is not stalled.
// All stages advance together; a stalled output freezes the whole pipeline,
// bubbles included, so nothing is dropped or repeated.
// Reset clears the valid bits and loads lambda = 1.25, mu = 1.0.
`default_nettype none

module finite_strain_stress_2d_core import fss2d_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire grad_t                 s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output stress_t                    m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    modulus_t lame_lambda_reg;
    modulus_t shear_modulus_reg;
    logic     advance;
    logic     strain_valid, stress_valid;
    tensor_t  strain_f, stress_f;
    sym_t     strain_e, stress_s;

    // advance whenever the output register is free or being drained
    assign advance   = !m_valid || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lame_lambda_reg   <= LAMBDA_RESET;
            shear_modulus_reg <= MU_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LAME_LAMBDA:   lame_lambda_reg   <= cfg_data[REG_W-1:0];
                CFG_SHEAR_MODULUS: shear_modulus_reg <= cfg_data[REG_W-1:0];
                default: begin
                    // unknown register: drop the write
                end
            endcase
        end
    end

    fss2d_strain u_strain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_valid  (s_valid),
        .in_grad   (s_data),
        .out_valid (strain_valid),
        .out_f     (strain_f),
        .out_e     (strain_e)
    );

    fss2d_stress u_stress (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (advance),
        .lame_lambda   (lame_lambda_reg),
        .shear_modulus (shear_modulus_reg),
        .in_valid      (strain_valid),
        .in_f          (strain_f),
        .in_e          (strain_e),
        .out_valid     (stress_valid),
        .out_f         (stress_f),
        .out_s         (stress_s)
    );

    fss2d_piola u_piola (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_valid  (stress_valid),
        .in_f      (stress_f),
        .in_s      (stress_s),
        .out_valid (m_valid),
        .out_p     (m_data)
    );

endmodule

`default_nettype wire

[tb/sv/fss2d_check_pkg.sv]
// Scoreboard for the 2x2 finite-strain stress core: bit-exact stress predictor
// and the queue of stress results still owed by the block. Depends on fss2d_pkg.
package fss2d_check_pkg;
    import fss2d_pkg::*;

    localparam longint Q_ONE = 64'sd65536;
    localparam longint Q_HI  = 64'sd2147483647;
    localparam longint Q_LO  = -64'sd2147483648;

    class stress_scoreboard;
        modulus_t    lambda_q;
        modulus_t    mu_q;
        stress_t     expected_stress[$];
        int unsigned mismatches;
        int unsigned results_checked;

        function new();
            lambda_q = LAMBDA_RESET;
            mu_q = MU_RESET;
            mismatches = 0;
            results_checked = 0;
        endfunction

        // unknown indexes drop, bit 31 of the data drops
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_LAME_LAMBDA) begin
                lambda_q = value[REG_W-1:0];
            end else if (idx == CFG_SHEAR_MODULUS) begin
                mu_q = value[REG_W-1:0];
            end
        endfunction

        static function longint clamp_q(longint v);
            if (v > Q_HI) begin
                return Q_HI;
            end else if (v < Q_LO) begin
                return Q_LO;
            end
            return v;
        endfunction

        // Q32.32 to Q16.16, ties toward plus infinity
        static function longint round_q(longint p);
            return (p + 64'sd32768) >>> 16;
        endfunction

        function stress_t piola_stress(grad_t g);
            longint f00, f01, f10, f11;
            longint c00, c01, c11;
            longint e00, e01, e11;
            longint lam, mu, tr, t;
            longint s00, s01, s11;
            stress_t r;
            f00 = clamp_q(longint'(g.grad_00) + Q_ONE);
            f01 = clamp_q(longint'(g.grad_01));
            f10 = clamp_q(longint'(g.grad_10));
            f11 = clamp_q(longint'(g.grad_11) + Q_ONE);
            // right Cauchy-Green tensor, no clamp
            c00 = round_q(f00 * f00) + round_q(f10 * f10);
            c01 = round_q(f00 * f01) + round_q(f10 * f11);
            c11 = round_q(f01 * f01) + round_q(f11 * f11);
            e00 = clamp_q((c00 - Q_ONE + 1) >>> 1);
            e01 = clamp_q((c01 + 1) >>> 1);
            e11 = clamp_q((c11 - Q_ONE + 1) >>> 1);
            lam = longint'(lambda_q);
            mu = longint'(mu_q);
            tr = clamp_q(e00 + e11);
            t = round_q(lam * tr);
            s00 = clamp_q(t + 2 * round_q(mu * e00));
            s01 = clamp_q(2 * round_q(mu * e01));
            s11 = clamp_q(t + 2 * round_q(mu * e11));
            // S is symmetric, so S_10 is s01
            r.stress_00 = q_t'(clamp_q(round_q(f00 * s00) + round_q(f01 * s01)));
            r.stress_01 = q_t'(clamp_q(round_q(f00 * s01) + round_q(f01 * s11)));
            r.stress_10 = q_t'(clamp_q(round_q(f10 * s00) + round_q(f11 * s01)));
            r.stress_11 = q_t'(clamp_q(round_q(f10 * s01) + round_q(f11 * s11)));
            return r;
        endfunction

        function void note_gradient(grad_t g);
            expected_stress.push_back(piola_stress(g));
        endfunction

        task flag_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_stress(stress_t got);
            string names [4] = '{"stress_00", "stress_01", "stress_10", "stress_11"};
            logic [127:0] got_v;
            logic [127:0] want_v;
            stress_t want;
            if (expected_stress.size() == 0) begin
                flag_mismatch($sformatf("stress %h with nothing expected", got));
                return;
            end
            want = expected_stress.pop_front();
            results_checked++;
            got_v = got;
            want_v = want;
            for (int k = 0; k < 4; k++) begin
                if (got_v[127-32*k -: 32] !== want_v[127-32*k -: 32]) begin
                    flag_mismatch($sformatf("%s got %h want %h", names[k],
                                            got_v[127-32*k -: 32], want_v[127-32*k -: 32]));
                end
            end
        endtask
    endclass

endpackage

[tb/sv/tb_top.sv]
// Top of the testbench for finite_strain_stress_2d_core: clock, reset, stimulus,
// result sink, monitor and watchdog. Depends on fss2d_pkg and fss2d_check_pkg.
module tb_top;
    import fss2d_pkg::*;
    import fss2d_check_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT      = 3000;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int RANDOM_PER_PHASE = 276;
    localparam int DEFAULT_IDLE_PCT = 26;
    localparam int NO_EVENT         = -1;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = CFG_IDX_W'(3);

    localparam q_t Q_MAX  = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN  = 32'sh8000_0000;
    localparam q_t Q_HALF = 32'sh0000_8000;
    localparam q_t Q_UNIT = 32'sh0001_0000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    grad_t                 s_data;
    logic                  m_valid;
    logic                  m_ready;
    stress_t               m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    stress_scoreboard sb;
    int          src_idle_pct;
    int          sink_idle_pct;
    bit          hold_sink;
    int unsigned gradients_in;
    int unsigned cfg_writes;
    int unsigned quiet_cycles;
    int unsigned settings_run;

    finite_strain_stress_2d_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic grad_t make_gradient(q_t g00, q_t g01, q_t g10, q_t g11);
        grad_t g;
        g.grad_00 = g00;
        g.grad_01 = g01;
        g.grad_10 = g10;
        g.grad_11 = g11;
        return g;
    endfunction

    // mostly physical strains, some wide values, full-range noise and corners
    function automatic q_t random_entry();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40) begin
            return q_t'(int'($urandom_range(262143)) - 131072);
        end else if (sel < 70) begin
            return q_t'(int'($urandom_range(2097151)) - 1048576);
        end else if (sel < 85) begin
            return q_t'($urandom);
        end
        case ($urandom_range(6))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return -Q_UNIT;
            3: return Q_HALF;
            4: return -Q_HALF;
            5: return q_t'(1);
            default: return q_t'(0);
        endcase
    endfunction

    function automatic grad_t random_gradient();
        return make_gradient(random_entry(), random_entry(), random_entry(), random_entry());
    endfunction

    // call at a clock edge; returns at the edge of the transfer with valid still high
    task automatic offer_gradient(grad_t g);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= g;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_stress.size() != 0) @(posedge aclk);
    endtask

    task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] lam, logic [CFG_DATA_W-1:0] mu,
                             int src_idle, int sink_idle, int hold_at, int pause_at);
        write_config(CFG_LAME_LAMBDA, lam);
        write_config(CFG_SHEAR_MODULUS, mu);
        src_idle_pct = src_idle;
        sink_idle_pct = sink_idle;
        settings_run++;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == hold_at) begin
                hold_sink = 1'b1;
            end
            if (n == pause_at) begin
                drain_results();
            end
            offer_gradient(random_gradient());
        end
        drain_results();
    endtask

    // result sink
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                hold_sink = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
                @(posedge aclk);
            end
        end
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_gradient(s_data);
                gradients_in++;
            end
            if (m_valid && m_ready) begin
                sb.check_stress(m_data);
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
                cfg_writes++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout after %0d cycles without a transfer", quiet_cycles);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LAME_LAMBDA;
        cfg_data = '0;
        src_idle_pct = DEFAULT_IDLE_PCT;
        sink_idle_pct = DEFAULT_IDLE_PCT;
        hold_sink = 1'b0;
        gradients_in = 0;
        cfg_writes = 0;
        quiet_cycles = 0;
        settings_run = 1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners under the reset moduli
        offer_gradient(make_gradient(0, 0, 0, 0));
        offer_gradient(make_gradient(Q_HALF, Q_HALF, Q_HALF, Q_HALF));
        offer_gradient(make_gradient(-Q_HALF, -Q_HALF, -Q_HALF, -Q_HALF));
        offer_gradient(make_gradient(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        offer_gradient(make_gradient(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        offer_gradient(make_gradient(-Q_UNIT, 0, 0, -Q_UNIT));
        offer_gradient(make_gradient(Q_MAX, 0, 0, 0));
        offer_gradient(make_gradient(0, 0, 0, Q_MAX));
        offer_gradient(make_gradient(0, Q_MAX, Q_MIN, 0));
        offer_gradient(make_gradient(0, Q_MIN, Q_MAX, 0));
        offer_gradient(make_gradient(Q_UNIT, 0, 0, Q_UNIT));
        offer_gradient(make_gradient(0, 32'sd6554, 0, 0));
        offer_gradient(make_gradient(-Q_HALF, 0, 0, -Q_HALF));
        offer_gradient(make_gradient(Q_MIN, 32'sd1, -32'sd1, Q_MIN));
        offer_gradient(make_gradient(32'sd1, -32'sd1, 32'sd1, -32'sd1));
        offer_gradient(make_gradient(32'sh7FFF_0000, 32'sh7FFF_0000, 0, 32'sh7FFF_0000));
        offer_gradient(make_gradient(32'sh4000_0000, -32'sh4000_0000, 32'sh4000_0000,
                                     -32'sh4000_0000));
        drain_results();

        run_phase(32'd0, 32'd0, DEFAULT_IDLE_PCT, DEFAULT_IDLE_PCT, NO_EVENT, NO_EVENT);
        // all ones: bit 31 must drop, leaving the largest moduli
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, DEFAULT_IDLE_PCT, DEFAULT_IDLE_PCT,
                  NO_EVENT, NO_EVENT);
        run_phase($urandom_range(32'h0010_0000), $urandom_range(32'h0010_0000), 0, 0,
                  NO_EVENT, NO_EVENT);
        // receiver holds off while the sender keeps offering
        run_phase($urandom, $urandom_range(32'h0004_0000), DEFAULT_IDLE_PCT, DEFAULT_IDLE_PCT,
                  40, NO_EVENT);
        write_config(CFG_UNUSED_2, $urandom);
        write_config(CFG_UNUSED_3, $urandom);
        run_phase({1'b0, LAMBDA_RESET}, {1'b0, MU_RESET}, DEFAULT_IDLE_PCT, DEFAULT_IDLE_PCT,
                  NO_EVENT, 100);
        run_phase($urandom_range(32'h0080_0000), $urandom_range(32'h0002_0000),
                  DEFAULT_IDLE_PCT, DEFAULT_IDLE_PCT, NO_EVENT, NO_EVENT);
        run_phase(32'd1, 32'h7FFF_FFFF, DEFAULT_IDLE_PCT, DEFAULT_IDLE_PCT, NO_EVENT, NO_EVENT);

        repeat (24) @(posedge aclk);
        $display("covered %0d gradients and %0d stress results over %0d modulus settings, %0d writes",
                 gradients_in, sb.results_checked, settings_run, cfg_writes);
        if (sb.mismatches == 0 && sb.expected_stress.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
src/fss2d_pkg.sv
src/fss2d_strain.sv
src/fss2d_stress.sv
src/fss2d_piola.sv
src/finite_strain_stress_2d_core.sv
tb/sv/fss2d_check_pkg.sv
tb/sv/tb_top.sv
